// File: src/cpsp_pkg.sv
package cpsp_pkg;

    typedef struct packed {
        logic        op;
        logic [31:0] capture_value;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [2:0]  mode;
        logic        press_taken;
        logic [26:0] freq_hz;
        logic [7:0]  live_angle;
        logic [9:0]  pulse_one;
        logic [9:0]  pulse_two;
        logic [9:0]  pulse_three;
    } t_out_item;

    typedef enum logic [2:0] {
        MODE_REST     = 3'd0,
        MODE_RECHARGE = 3'd1,
        MODE_SET_ONE  = 3'd2,
        MODE_SET_TWO  = 3'd3,
        MODE_WAIT     = 3'd4,
        MODE_FIRE     = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_FREQ,
        ST_ANGLE,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_PRESS,
        ST_OUT
    } t_state;

    localparam logic [2:0] REG_CLOCK_HZ   = 3'd0;
    localparam logic [2:0] REG_FREQ_LOW   = 3'd1;
    localparam logic [2:0] REG_FREQ_HIGH  = 3'd2;
    localparam logic [2:0] REG_DEBOUNCE   = 3'd3;
    localparam logic [2:0] REG_SERVO1_MIN = 3'd4;
    localparam logic [2:0] REG_SERVO1_MAX = 3'd5;

endpackage

// File: src/cpsp_div.sv
// Restoring divider, one quotient bit per cycle.
module cpsp_div #(
    parameter int NW = 40,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    import cpsp_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;

    assign w_trial = {r_rem[DW-1:0], r_q[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (!w_diff[DW]) begin
                    r_rem <= w_diff;
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: src/capture_period_to_servo_pulses_unit.sv
// Channel | direction | handshake       | payload
// in      | input     | i_valid/o_stall | cpsp_pkg::t_in_item
// out     | output    | o_valid/i_stall | cpsp_pkg::t_out_item
// cfg     | input     | i_cfg_we        | i_cfg_index, i_cfg_data
//
// A capture edge after the first makes six passes through one shared restoring
// divider (average, frequency, angle, three pulse scales); each pass starts the
// divider, which hands its 40-bit quotient on when done. The next item is taken
// only after the result has been loaded into the output register. A press takes
// one pass. A first edge is only stored and does not stall the input.
// Reset is synchronous, active low, and restores the state, configuration and
// handshake registers; the output payload and working data are not reset.
// The input stalls while an item is in work; a finished item holds in the last
// step while the previous result is still stalled at the output.
module capture_period_to_servo_pulses_unit #(
    parameter int WINDOW = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cpsp_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cpsp_pkg::t_out_item  o_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [26:0]          i_cfg_data
);
    import cpsp_pkg::*;

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = $clog2(WINDOW + 1);
    localparam int TW = 32 + FW;
    localparam int NW = 40;
    localparam int DW = 32;

    // configuration
    logic [26:0] r_clock_hz, r_freq_low, r_freq_high;
    logic [15:0] r_debounce;
    logic [7:0]  r_s1_min, r_s1_max;

    // block state
    logic [31:0] r_prev;
    logic        r_have_first;
    logic [31:0] r_win [WINDOW];
    logic [PW-1:0] r_pos;
    logic [FW-1:0] r_fill;
    logic [TW-1:0] r_total;
    t_mode       r_mode;
    logic [7:0]  r_held1, r_held2;
    logic [31:0] r_last_press;
    logic [26:0] r_last_freq;

    // sequencer
    t_state      r_state, n_state;
    t_out_item   r_out;
    logic        r_out_valid;
    logic [7:0]  r_live;
    logic        r_press_item;
    logic        r_taken;
    t_mode       r_old_mode;
    logic        r_avg_zero;
    logic [9:0]  r_p1, r_p2, r_p3;
    logic        r_kick;
    logic        w_enter;

    // divider
    logic [NW-1:0] w_num;
    logic [DW-1:0] w_den;
    logic          w_done;
    logic [NW-1:0] w_quot;

    cpsp_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_kick),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    logic w_accept;
    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    // debounce test, wrapping time difference
    logic w_press_ok;
    assign w_press_ok = (i_data.now_ms - r_last_press) > 32'(r_debounce);

    logic [31:0] w_period;
    assign w_period = i_data.capture_value - r_prev;

    // clamp of the last frequency for the angle map
    logic [26:0] w_fx;
    logic [26:0] w_dx;
    logic        w_band_ok;
    assign w_band_ok = r_freq_high > r_freq_low;
    always_comb begin
        w_fx = r_last_freq;
        if (w_fx < r_freq_low)  w_fx = r_freq_low;
        if (w_fx > r_freq_high) w_fx = r_freq_high;
    end
    assign w_dx = w_fx - r_freq_low;

    // 180*x = 128x + 32x + 16x + 4x
    logic [NW-1:0] w_x180;
    assign w_x180 = (NW'(w_dx) << 7) + (NW'(w_dx) << 5)
                  + (NW'(w_dx) << 4) + (NW'(w_dx) << 2);

    logic [7:0] w_angle_q;
    assign w_angle_q = w_band_ok ? w_quot[7:0] : 8'd0;

    // servo angle for the pulse currently being scaled
    logic [7:0] w_ang, w_lo, w_hi, w_a;
    always_comb begin
        w_lo = 8'd0;
        w_hi = 8'd180;
        unique case (r_state)
            ST_P1: begin
                w_lo = (r_s1_min > 8'd180) ? 8'd180 : r_s1_min;
                w_hi = (r_s1_max > 8'd180) ? 8'd180 : r_s1_max;
                if (r_mode == MODE_REST || r_mode == MODE_RECHARGE) w_ang = r_s1_max;
                else if (r_mode == MODE_SET_ONE) w_ang = r_live;
                else w_ang = r_held1;
            end
            ST_P2: w_ang = (r_mode == MODE_SET_TWO) ? r_live : r_held2;
            default: w_ang = (r_mode == MODE_REST || r_mode == MODE_FIRE) ? 8'd180 : 8'd90;
        endcase
        w_a = w_ang;
        if (w_a < w_lo) w_a = w_lo;
        if (w_a > w_hi) w_a = w_hi;
    end

    // 750*a = 512a + 256a - 16a - 2a
    logic [NW-1:0] w_x750;
    assign w_x750 = (NW'(w_a) << 9) + (NW'(w_a) << 8)
                  - (NW'(w_a) << 4) - (NW'(w_a) << 1);

    // divider operands per step, stable through the start cycle
    always_comb begin
        w_num = w_x750;
        w_den = DW'(180);
        unique case (r_state) inside
            ST_AVG: begin
                w_num = NW'(r_total);
                w_den = DW'(r_fill);
            end
            ST_FREQ: begin
                w_num = NW'(r_clock_hz);
                w_den = w_quot[DW-1:0];
            end
            ST_ANGLE, ST_PRESS: begin
                w_num = w_x180;
                w_den = DW'(r_freq_high - r_freq_low);
            end
            default: ;
        endcase
    end

    // next state and divider kick
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) begin
                if (i_data.op) n_state = ST_PRESS;
                else if (r_have_first) n_state = ST_AVG;
            end
            ST_AVG:   if (w_done) n_state = ST_FREQ;
            ST_FREQ:  if (w_done) n_state = ST_ANGLE;
            ST_ANGLE: if (w_done) n_state = ST_P1;
            ST_P1:    if (w_done) n_state = ST_P2;
            ST_P2:    if (w_done) n_state = ST_P3;
            ST_P3:    if (w_done) n_state = ST_OUT;
            ST_PRESS: if (w_done) n_state = ST_OUT;
            ST_OUT:   if (!(r_out_valid && i_stall)) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
        w_enter = (n_state != r_state) && (n_state != ST_IDLE) && (n_state != ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz   <= 27'd32000000;
            r_freq_low   <= 27'd29000;
            r_freq_high  <= 27'd62000;
            r_debounce   <= 16'd200;
            r_s1_min     <= 8'd40;
            r_s1_max     <= 8'd125;
            r_prev       <= '0;
            r_have_first <= 1'b0;
            r_pos        <= '0;
            r_fill       <= '0;
            r_total      <= '0;
            r_mode       <= MODE_REST;
            r_held1      <= 8'd90;
            r_held2      <= 8'd90;
            r_last_press <= '0;
            r_last_freq  <= '0;
            r_out_valid  <= 1'b0;
            r_kick       <= 1'b0;
            for (int i = 0; i < WINDOW; i++) r_win[i] <= '0;
        end else begin
            r_kick <= w_enter;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CLOCK_HZ:   r_clock_hz  <= i_cfg_data;
                    REG_FREQ_LOW:   r_freq_low  <= i_cfg_data;
                    REG_FREQ_HIGH:  r_freq_high <= i_cfg_data;
                    REG_DEBOUNCE:   r_debounce  <= i_cfg_data[15:0];
                    REG_SERVO1_MIN: r_s1_min    <= i_cfg_data[7:0];
                    REG_SERVO1_MAX: r_s1_max    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // load a new result once the output register is free, drop it when taken
            if (r_state == ST_OUT && !(r_out_valid && i_stall)) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)                   r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: if (w_accept) begin
                    r_press_item <= i_data.op;
                    r_old_mode   <= r_mode;
                    if (i_data.op) begin
                        if (w_press_ok) begin
                            r_taken      <= 1'b1;
                            r_last_press <= i_data.now_ms;
                            unique case (r_mode)
                                MODE_REST:     r_mode <= MODE_RECHARGE;
                                MODE_RECHARGE: r_mode <= MODE_SET_ONE;
                                MODE_SET_ONE:  r_mode <= MODE_SET_TWO;
                                MODE_SET_TWO:  r_mode <= MODE_WAIT;
                                MODE_WAIT:     r_mode <= MODE_FIRE;
                                default:       r_mode <= MODE_REST;
                            endcase
                        end else begin
                            r_taken <= 1'b0;
                        end
                    end else begin
                        r_taken <= 1'b0;
                        if (!r_have_first) begin
                            r_prev       <= i_data.capture_value;
                            r_have_first <= 1'b1;
                        end else begin
                            // drop the oldest period, add the new one
                            r_prev       <= i_data.capture_value;
                            r_total      <= r_total - TW'(r_win[r_pos]) + TW'(w_period);
                            r_win[r_pos] <= w_period;
                            r_pos        <= (r_pos == PW'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                            if (r_fill != FW'(WINDOW)) r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                ST_AVG:   if (w_done) r_avg_zero <= (w_quot == '0);
                ST_FREQ:  if (w_done) r_last_freq <= r_avg_zero ? 27'd0 : w_quot[26:0];
                ST_ANGLE: if (w_done) r_live <= w_angle_q;
                ST_P1:    if (w_done) r_p1 <= w_quot[9:0] + 10'd150;
                ST_P2:    if (w_done) r_p2 <= w_quot[9:0] + 10'd150;
                ST_P3:    if (w_done) r_p3 <= w_quot[9:0] + 10'd150;
                ST_PRESS: if (w_done) begin
                    if (r_taken && r_old_mode == MODE_SET_ONE) r_held1 <= w_angle_q;
                    if (r_taken && r_old_mode == MODE_SET_TWO) r_held2 <= w_angle_q;
                    r_live <= w_angle_q;
                end
                ST_OUT: if (!(r_out_valid && i_stall)) begin
                    r_out.kind        <= r_press_item;
                    r_out.mode        <= r_mode;
                    r_out.press_taken <= r_press_item & r_taken;
                    r_out.freq_hz     <= r_last_freq;
                    r_out.live_angle  <= r_live;
                    r_out.pulse_one   <= r_press_item ? 10'd0 : r_p1;
                    r_out.pulse_two   <= r_press_item ? 10'd0 : r_p2;
                    r_out.pulse_three <= r_press_item ? 10'd0 : r_p3;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule

// File: src/cpsp_checker.sv
module cpsp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input cpsp_pkg::t_out_item o_data
);
    import cpsp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.mode <= 3'd5)
        else $error("mode out of range");

    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.kind |-> o_data.pulse_three == 10'd900
                                 || o_data.pulse_three == 10'd525)
        else $error("release pulse wrong");

    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind |-> o_data.pulse_one == 10'd0
                                && o_data.pulse_two == 10'd0
                                && o_data.pulse_three == 10'd0)
        else $error("press report carries pulses");

    a_stall_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_stall) && !$isunknown(o_valid))
        else $error("handshake unknown");
endmodule

bind capture_period_to_servo_pulses_unit cpsp_checker u_chk (.*);

// File: sim/tb_top.sv
module tb_top;
    import cpsp_pkg::*;

    localparam int WIN = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in_item i_data;
    logic o_valid;
    logic i_stall;
    t_out_item o_data;
    logic i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [26:0] i_cfg_data;

    capture_period_to_servo_pulses_unit #(.WINDOW(WIN)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predicted servo state and register copies
    logic [26:0] clk_hz_r, flo_r, fhi_r;
    logic [15:0] deb_r;
    logic [7:0]  s1min_r, s1max_r;
    logic [31:0] prev_cap;
    logic        seen_edge;
    logic [31:0] period_win [WIN];
    int          win_pos, win_fill;
    logic [35:0] win_sum;
    logic [2:0]  cur_mode;
    logic [7:0]  hold_one, hold_two;
    logic [31:0] last_press, last_hz;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        mismatch_count;
    int        results_seen;
    bit        sender_idle_ok;   // sender may insert random gaps
    bit        recv_idle_ok;     // receiver may stall at random
    bit        hold_off_go;      // request one long receiver stall
    int        hold_off_cycles;  // long receiver stall, counted down below
    bit        hold_off_used;
    bit        pause_sender;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [7:0] angle_for(input logic [31:0] f);
        logic [63:0] x;
        if (fhi_r <= flo_r) return 8'd0;
        x = f;
        if (x < flo_r) x = flo_r;
        if (x > fhi_r) x = fhi_r;
        return 8'(((x - flo_r) * 180) / (fhi_r - flo_r));
    endfunction

    function automatic logic [9:0] pulse_for(input logic [31:0] a,
                                             input logic [31:0] lo,
                                             input logic [31:0] hi);
        if (lo > 180) lo = 180;
        if (hi > 180) hi = 180;
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        return 10'(150 + (a * 750) / 180);
    endfunction

    task automatic reset_prediction();
        clk_hz_r = 27'd32000000; flo_r = 27'd29000; fhi_r = 27'd62000;
        deb_r = 16'd200; s1min_r = 8'd40; s1max_r = 8'd125;
        prev_cap = '0; seen_edge = 1'b0;
        foreach (period_win[i]) period_win[i] = '0;
        win_pos = 0; win_fill = 0; win_sum = '0;
        cur_mode = MODE_REST; hold_one = 8'd90; hold_two = 8'd90;
        last_press = '0; last_hz = '0;
    endtask

    // Advance the predicted state by one transaction, queue its result if any
    task automatic predict_servo(input t_in_item it);
        t_out_item r;
        logic [31:0] period, live, a1, a2, a3;
        logic [35:0] avg;
        r = '0;
        if (it.op) begin
            if (32'(it.now_ms - last_press) > deb_r) begin
                r.press_taken = 1'b1;
                last_press = it.now_ms;
                case (cur_mode)
                    MODE_REST: cur_mode = MODE_RECHARGE;
                    MODE_RECHARGE: cur_mode = MODE_SET_ONE;
                    MODE_SET_ONE: begin
                        hold_one = angle_for(last_hz); cur_mode = MODE_SET_TWO;
                    end
                    MODE_SET_TWO: begin
                        hold_two = angle_for(last_hz); cur_mode = MODE_WAIT;
                    end
                    MODE_WAIT: cur_mode = MODE_FIRE;
                    default: cur_mode = MODE_REST;
                endcase
            end
            r.kind = 1'b1;
            r.mode = cur_mode;
            r.freq_hz = 27'(last_hz);
            r.live_angle = angle_for(last_hz);
            expected_results.push_back(r);
            return;
        end
        if (!seen_edge) begin
            prev_cap = it.capture_value;
            seen_edge = 1'b1;
            return;
        end
        period = it.capture_value - prev_cap;
        prev_cap = it.capture_value;
        win_sum = win_sum - period_win[win_pos] + period;
        period_win[win_pos] = period;
        win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
        if (win_fill < WIN) win_fill++;
        avg = win_sum / win_fill;
        last_hz = (avg == 0) ? 32'd0 : 32'(36'(clk_hz_r) / avg);
        live = angle_for(last_hz);
        if (cur_mode == MODE_REST || cur_mode == MODE_RECHARGE) a1 = s1max_r;
        else if (cur_mode == MODE_SET_ONE) a1 = live;
        else a1 = hold_one;
        a2 = (cur_mode == MODE_SET_TWO) ? live : hold_two;
        a3 = (cur_mode == MODE_REST || cur_mode == MODE_FIRE) ? 180 : 90;
        r.kind = 1'b0;
        r.mode = cur_mode;
        r.freq_hz = 27'(last_hz);
        r.live_angle = 8'(live);
        r.pulse_one = pulse_for(a1, s1min_r, s1max_r);
        r.pulse_two = pulse_for(a2, 0, 180);
        r.pulse_three = pulse_for(a3, 0, 180);
        expected_results.push_back(r);
    endtask

    // Driver: hold the payload while stalled, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data  <= '0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) predict_servo(i_data);
            if (pending_items.size() > 0 && !pause_sender &&
                !(sender_idle_ok && $urandom_range(99) < 19)) begin
                i_valid <= 1'b1;
                i_data  <= pending_items.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall         <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_used   <= 1'b0;
        end else if (hold_off_go && !hold_off_used) begin
            hold_off_used   <= 1'b1;
            hold_off_cycles <= 2999;
            i_stall         <= 1'b1;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= recv_idle_ok && ($urandom_range(99) < 19);
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_data.kind), 32'd0);
            end else begin
                w = expected_results.pop_front();
                if (o_data.kind !== w.kind) report_mismatch("kind", o_data.kind, w.kind);
                if (o_data.mode !== w.mode) report_mismatch("mode", o_data.mode, w.mode);
                if (o_data.press_taken !== w.press_taken)
                    report_mismatch("press_taken", o_data.press_taken, w.press_taken);
                if (o_data.freq_hz !== w.freq_hz)
                    report_mismatch("freq_hz", o_data.freq_hz, w.freq_hz);
                if (o_data.live_angle !== w.live_angle)
                    report_mismatch("live_angle", o_data.live_angle, w.live_angle);
                if (o_data.pulse_one !== w.pulse_one)
                    report_mismatch("pulse_one", o_data.pulse_one, w.pulse_one);
                if (o_data.pulse_two !== w.pulse_two)
                    report_mismatch("pulse_two", o_data.pulse_two, w.pulse_two);
                if (o_data.pulse_three !== w.pulse_three)
                    report_mismatch("pulse_three", o_data.pulse_three, w.pulse_three);
            end
        end
    end

    function automatic t_in_item edge_item(input logic [31:0] v);
        t_in_item t;
        t.op = 1'b0; t.capture_value = v; t.now_ms = $urandom;
        return t;
    endfunction

    function automatic t_in_item press_item(input logic [31:0] ms);
        t_in_item t;
        t.op = 1'b1; t.capture_value = $urandom; t.now_ms = ms;
        return t;
    endfunction

    // Wait until the driver has handed over everything and all results came
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [26:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CLOCK_HZ:   clk_hz_r = val;
            REG_FREQ_LOW:   flo_r = val;
            REG_FREQ_HIGH:  fhi_r = val;
            REG_DEBOUNCE:   deb_r = val[15:0];
            REG_SERVO1_MIN: s1min_r = val[7:0];
            default:        s1max_r = val[7:0];
        endcase
    endtask

    // One random phase: periods near a target with jitter, presses, wrap jumps and target changes mixed in
    task automatic random_phase(input int count);
        logic [31:0] cap, ms, base;
        int sel;
        cap = $urandom; ms = $urandom;
        base = $urandom_range(2000, 200);
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 22) begin
                ms += ($urandom_range(3) == 0) ? $urandom_range(300)
                                               : $urandom_range(70000);
                pending_items.push_back(press_item(ms));
            end else if (sel < 27) begin
                cap = $urandom;  // noise: arbitrary wrap jumps
                pending_items.push_back(edge_item(cap));
            end else if (sel < 30) begin
                base = $urandom_range(60000, 1);
                cap += base;
                pending_items.push_back(edge_item(cap));
            end else begin
                cap += base + $urandom_range(base / 8) - base / 16;
                pending_items.push_back(edge_item(cap));
            end
        end
    endtask

    initial begin
        mismatch_count = 0; results_seen = 0;
        sender_idle_ok = 0; recv_idle_ok = 0; hold_off_go = 0; pause_sender = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = REG_CLOCK_HZ; i_cfg_data = '0;
        reset_prediction();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: press before any edge, first edge alone, zero period,
        // extremes of the capture and time fields, the full mode cycle
        pending_items.push_back(press_item(32'd0));
        pending_items.push_back(press_item(32'd201));
        pending_items.push_back(edge_item(32'hFFFF_FFFF));
        pending_items.push_back(edge_item(32'hFFFF_FFFF));
        pending_items.push_back(edge_item(32'd999));
        pending_items.push_back(edge_item(32'd1999));
        pending_items.push_back(press_item(32'd250));
        pending_items.push_back(edge_item(32'd2599));
        pending_items.push_back(press_item(32'd1000));
        pending_items.push_back(edge_item(32'd3099));
        pending_items.push_back(press_item(32'd2000));
        pending_items.push_back(edge_item(32'd3599));
        pending_items.push_back(press_item(32'd3000));
        pending_items.push_back(press_item(32'hFFFF_FFFF));
        pending_items.push_back(press_item(32'd500));   // wraps past the last press
        pending_items.push_back(press_item(32'd501));   // bounces
        pending_items.push_back(edge_item(32'h8000_0000));
        pending_items.push_back(edge_item(32'h7FFF_FFFF));
        for (int n = 0; n < 6; n++) pending_items.push_back(edge_item(32'h7FFF_FFFF + n));
        drain();

        // Register extremes: tiny clock, inverted band, servo limits crossed
        write_reg(REG_CLOCK_HZ, 27'd1);
        write_reg(REG_FREQ_LOW, 27'd100000000);
        write_reg(REG_FREQ_HIGH, 27'd2);
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_SERVO1_MIN, 8'd255);
        write_reg(REG_SERVO1_MAX, 8'd0);
        sender_idle_ok = 1; recv_idle_ok = 1;
        random_phase(120);
        drain();

        write_reg(REG_CLOCK_HZ, 27'd100000000);
        write_reg(REG_FREQ_LOW, 27'd1);
        write_reg(REG_FREQ_HIGH, 27'd100000000);
        write_reg(REG_DEBOUNCE, 16'hFFFF);
        write_reg(REG_SERVO1_MIN, 8'd0);
        write_reg(REG_SERVO1_MAX, 8'd180);
        random_phase(150);
        // Receiver holds off while the sender keeps offering
        hold_off_go = 1;
        drain();

        // Sender pauses until every result has come, then resumes
        random_phase(100);
        repeat (2000) @(posedge i_clk);
        pause_sender = 1;
        while (i_valid || expected_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        pause_sender = 0;
        drain();

        // Default-like band with random settings, one of the phases a no-idle stretch
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_CLOCK_HZ, 27'($urandom_range(100000000, 1)));
            write_reg(REG_FREQ_LOW, 27'($urandom_range(60000, 1)));
            write_reg(REG_FREQ_HIGH, 27'($urandom_range(200000, 2)));
            write_reg(REG_DEBOUNCE, 16'($urandom_range(65535)));
            write_reg(REG_SERVO1_MIN, 8'($urandom_range(255)));
            write_reg(REG_SERVO1_MAX, 8'($urandom_range(255)));
            if (ph == 3) begin
                sender_idle_ok = 0; recv_idle_ok = 0;
            end else begin
                sender_idle_ok = 1; recv_idle_ok = 1;
            end
            random_phase(150);
            drain();
        end

        $display("Covered %0d results over capture edges and button presses,", results_seen);
        $display("with register extremes, long receiver hold-off and sender pauses.");
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: files.f
src/cpsp_pkg.sv
src/cpsp_div.sv
src/capture_period_to_servo_pulses_unit.sv
src/cpsp_checker.sv
sim/tb_top.sv
